// ===== hw/rtl/potbc_pkg.sv =====
`timescale 1ns / 1ps

package potbc_pkg;

    // Fixed point formats
    localparam int AXIS_FRAC = 14;
    localparam logic signed [15:0] AXIS_ONE = 16'sd16384;
    localparam logic signed [15:0] AXIS_NEG_ONE = -16'sd16384;

    // Region codes on the result
    localparam logic [3:0] REGION_INSIDE       = 4'd0;
    localparam logic [3:0] REGION_LEFT         = 4'd1;
    localparam logic [3:0] REGION_RIGHT        = 4'd2;
    localparam logic [3:0] REGION_BOTTOM       = 4'd3;
    localparam logic [3:0] REGION_TOP          = 4'd4;
    localparam logic [3:0] REGION_LEFT_TOP     = 4'd5;
    localparam logic [3:0] REGION_LEFT_BOTTOM  = 4'd6;
    localparam logic [3:0] REGION_RIGHT_TOP    = 4'd7;
    localparam logic [3:0] REGION_RIGHT_BOTTOM = 4'd8;

    // Face direction codes, also the inside tie order
    localparam logic [1:0] DIR_LEFT   = 2'd0;
    localparam logic [1:0] DIR_RIGHT  = 2'd1;
    localparam logic [1:0] DIR_BOTTOM = 2'd2;
    localparam logic [1:0] DIR_TOP    = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] CFG_CENTER_X    = 3'd0;
    localparam logic [2:0] CFG_CENTER_Y    = 3'd1;
    localparam logic [2:0] CFG_HALF_WIDTH  = 3'd2;
    localparam logic [2:0] CFG_HALF_HEIGHT = 3'd3;
    localparam logic [2:0] CFG_AXIS_COS    = 3'd4;
    localparam logic [2:0] CFG_AXIS_SIN    = 3'd5;

    localparam int FIFO_DEPTH = 4;
    localparam logic signed [31:0] INT32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] INT32_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic [30:0]        half_width;
        logic [30:0]        half_height;
        logic signed [15:0] axis_cos;
        logic signed [15:0] axis_sin;
    } cfg_t;

    // Classified item between front and back
    typedef struct packed {
        logic [3:0]         region;
        logic               corner;
        logic               ex_neg;
        logic               ey_neg;
        logic [34:0]        ax;
        logic [34:0]        ay;
        logic signed [31:0] sdist;
        logic signed [15:0] lnx;
        logic signed [15:0] lny;
    } entry_t;

    // Item data carried beside the back arithmetic
    typedef struct packed {
        logic [3:0]         region;
        logic               corner;
        logic               ex_neg;
        logic               ey_neg;
        logic               sat;
        logic signed [31:0] sdist;
        logic signed [15:0] lnx;
        logic signed [15:0] lny;
        logic [30:0]        na;
        logic [30:0]        nb;
    } side_t;

    function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
        logic signed [31:0] r;
        if ((v[37:31] == 7'h00) || (v[37:31] == 7'h7F))
        begin
            r = v[31:0];
        end
        else if (v[37])
        begin
            r = INT32_MIN;
        end
        else
        begin
            r = INT32_MAX;
        end
        return r;
    endfunction

    function automatic logic signed [15:0] clamp_axis(input logic signed [18:0] v);
        logic signed [15:0] r;
        if (v > 19'sd16384)
        begin
            r = AXIS_ONE;
        end
        else if (v < -19'sd16384)
        begin
            r = AXIS_NEG_ONE;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/potbc_fifo.sv =====
`timescale 1ns / 1ps

module potbc_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  potbc_pkg::entry_t     push_data,
    input  logic                  pop,
    output potbc_pkg::entry_t     head,
    output logic                  full,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    potbc_pkg::entry_t mem_reg [0:DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed beat
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hw/rtl/potbc_front.sv =====
`timescale 1ns / 1ps

module potbc_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  potbc_pkg::cfg_t       cfg,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic signed [31:0]    point_x,
    input  logic signed [31:0]    point_y,
    input  logic                  fifo_full,
    output logic                  push,
    output potbc_pkg::entry_t     push_data
);

    logic       en;
    logic [5:0] valid_reg;

    // Stage 1: offsets from the center
    logic signed [32:0] dx_reg, dy_reg;
    // Stage 2: rotation products
    logic signed [48:0] pxc_reg, pys_reg, pyc_reg, pxs_reg;
    // Stage 3: local coordinates
    logic signed [35:0] lx_reg, ly_reg;
    // Stage 4: face gaps
    logic signed [36:0] gl_reg, gr_reg, gb_reg, gt_reg;
    // Stage 5: region and pairwise minimum
    logic [3:0]         region_reg;
    logic               corner_reg, ex_neg_reg, ey_neg_reg;
    logic [34:0]        ax_reg, ay_reg;
    logic signed [36:0] fgap_reg, w01_reg, w23_reg;
    logic [1:0]         w01_idx_reg, w23_idx_reg;
    // Stage 6: queue entry
    potbc_pkg::entry_t  entry_reg;

    assign en        = !valid_reg[5] || !fifo_full;
    assign in_ready  = en;
    assign push      = valid_reg[5] && !fifo_full;
    assign push_data = entry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[4:0], in_valid};
        end
    end

    // Stage 5 combinational classification
    logic               left, right, bottom, top;
    logic signed [36:0] ngl, ngr, ngb, ngt;
    logic [3:0]         region_c;
    logic signed [36:0] fgap_c;

    always_comb
    begin
        left   = gl_reg[36];
        right  = gr_reg[36];
        bottom = gb_reg[36];
        top    = gt_reg[36];
        ngl    = -gl_reg;
        ngr    = -gr_reg;
        ngb    = -gb_reg;
        ngt    = -gt_reg;
        region_c = potbc_pkg::REGION_INSIDE;
        fgap_c   = '0;
        priority if (left || right)
        begin
            if (top)
            begin
                region_c = left ? potbc_pkg::REGION_LEFT_TOP : potbc_pkg::REGION_RIGHT_TOP;
            end
            else if (bottom)
            begin
                region_c = left ? potbc_pkg::REGION_LEFT_BOTTOM
                                : potbc_pkg::REGION_RIGHT_BOTTOM;
            end
            else
            begin
                region_c = left ? potbc_pkg::REGION_LEFT : potbc_pkg::REGION_RIGHT;
            end
            fgap_c = left ? gl_reg : gr_reg;
        end
        else if (bottom)
        begin
            region_c = potbc_pkg::REGION_BOTTOM;
            fgap_c   = gb_reg;
        end
        else if (top)
        begin
            region_c = potbc_pkg::REGION_TOP;
            fgap_c   = gt_reg;
        end
        else
        begin
            region_c = potbc_pkg::REGION_INSIDE;
            fgap_c   = '0;
        end
    end

    // Stage 6 combinational: final gap, distance, local normal
    logic signed [36:0] gap_c;
    logic [1:0]         dir_c;
    logic signed [15:0] lnx_c, lny_c;

    always_comb
    begin
        gap_c = fgap_reg;
        dir_c = potbc_pkg::DIR_LEFT;
        unique case (region_reg)
            potbc_pkg::REGION_INSIDE:
            begin
                if (w23_reg < w01_reg)
                begin
                    gap_c = w23_reg;
                    dir_c = w23_idx_reg;
                end
                else
                begin
                    gap_c = w01_reg;
                    dir_c = w01_idx_reg;
                end
            end
            potbc_pkg::REGION_LEFT:   dir_c = potbc_pkg::DIR_LEFT;
            potbc_pkg::REGION_RIGHT:  dir_c = potbc_pkg::DIR_RIGHT;
            potbc_pkg::REGION_BOTTOM: dir_c = potbc_pkg::DIR_BOTTOM;
            potbc_pkg::REGION_TOP:    dir_c = potbc_pkg::DIR_TOP;
            default:                  dir_c = potbc_pkg::DIR_LEFT;
        endcase
        lnx_c = '0;
        lny_c = '0;
        unique case (dir_c)
            potbc_pkg::DIR_LEFT:   lnx_c = potbc_pkg::AXIS_NEG_ONE;
            potbc_pkg::DIR_RIGHT:  lnx_c = potbc_pkg::AXIS_ONE;
            potbc_pkg::DIR_BOTTOM: lny_c = potbc_pkg::AXIS_NEG_ONE;
            potbc_pkg::DIR_TOP:    lny_c = potbc_pkg::AXIS_ONE;
        endcase
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg <= $signed({point_x[31], point_x}) - $signed({cfg.center_x[31], cfg.center_x});
            dy_reg <= $signed({point_y[31], point_y}) - $signed({cfg.center_y[31], cfg.center_y});

            pxc_reg <= dx_reg * cfg.axis_cos;
            pys_reg <= dy_reg * cfg.axis_sin;
            pyc_reg <= dy_reg * cfg.axis_cos;
            pxs_reg <= dx_reg * cfg.axis_sin;

            lx_reg <= 36'(($signed({pxc_reg[48], pxc_reg}) + $signed({pys_reg[48], pys_reg}))
                          >>> potbc_pkg::AXIS_FRAC);
            ly_reg <= 36'(($signed({pyc_reg[48], pyc_reg}) - $signed({pxs_reg[48], pxs_reg}))
                          >>> potbc_pkg::AXIS_FRAC);

            gl_reg <= $signed({lx_reg[35], lx_reg}) + $signed({6'b0, cfg.half_width});
            gr_reg <= $signed({6'b0, cfg.half_width}) - $signed({lx_reg[35], lx_reg});
            gb_reg <= $signed({ly_reg[35], ly_reg}) + $signed({6'b0, cfg.half_height});
            gt_reg <= $signed({6'b0, cfg.half_height}) - $signed({ly_reg[35], ly_reg});

            region_reg <= region_c;
            corner_reg <= (left || right) && (top || bottom);
            ex_neg_reg <= left;
            ey_neg_reg <= !top;
            ax_reg     <= left ? ngl[34:0] : ngr[34:0];
            ay_reg     <= top ? ngt[34:0] : ngb[34:0];
            fgap_reg   <= fgap_c;
            if (gr_reg < gl_reg)
            begin
                w01_reg     <= gr_reg;
                w01_idx_reg <= potbc_pkg::DIR_RIGHT;
            end
            else
            begin
                w01_reg     <= gl_reg;
                w01_idx_reg <= potbc_pkg::DIR_LEFT;
            end
            if (gt_reg < gb_reg)
            begin
                w23_reg     <= gt_reg;
                w23_idx_reg <= potbc_pkg::DIR_TOP;
            end
            else
            begin
                w23_reg     <= gb_reg;
                w23_idx_reg <= potbc_pkg::DIR_BOTTOM;
            end

            entry_reg.region <= region_reg;
            entry_reg.corner <= corner_reg;
            entry_reg.ex_neg <= ex_neg_reg;
            entry_reg.ey_neg <= ey_neg_reg;
            entry_reg.ax     <= ax_reg;
            entry_reg.ay     <= ay_reg;
            entry_reg.sdist  <= potbc_pkg::sat32(-$signed({gap_c[36], gap_c}));
            entry_reg.lnx    <= lnx_c;
            entry_reg.lny    <= lny_c;
        end
    end

endmodule

// ===== hw/rtl/potbc_sqrt.sv =====
`timescale 1ns / 1ps

// Floor square root, one result bit per stage
module potbc_sqrt (
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] rad,
    output logic [31:0] root
);

    logic [63:0] rem_reg  [0:31];
    logic [31:0] root_reg [0:31];

    genvar k;
    generate
        for (k = 0; k < 32; k++)
        begin : g_step
            localparam int Bit = 31 - k;
            logic [63:0] rem_in;
            logic [31:0] root_in;
            logic [64:0] sub;
            logic        take;

            if (k == 0)
            begin : g_first
                assign rem_in  = rad;
                assign root_in = '0;
            end
            else
            begin : g_next
                assign rem_in  = rem_reg[k-1];
                assign root_in = root_reg[k-1];
            end

            // Try setting this root bit
            assign sub  = ({33'b0, root_in} << (Bit + 1)) | (65'd1 << (2 * Bit));
            assign take = ({1'b0, rem_in} >= sub);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k]  <= take ? 64'({1'b0, rem_in} - sub) : rem_in;
                    root_reg[k] <= take ? (root_in | (32'd1 << Bit)) : root_in;
                end
            end
        end
    endgenerate

    assign root = root_reg[31];

endmodule

// ===== hw/rtl/potbc_div.sv =====
`timescale 1ns / 1ps

// Restoring divider, 15 quotient bits, one bit per stage
module potbc_div (
    input  logic        clk,
    input  logic        en,
    input  logic [45:0] num,
    input  logic [31:0] den,
    output logic [14:0] quo
);

    logic [45:0] rem_reg [0:14];
    logic [31:0] den_reg [0:14];
    logic [14:0] quo_reg [0:14];

    genvar k;
    generate
        for (k = 0; k < 15; k++)
        begin : g_step
            localparam int Bit = 14 - k;
            logic [45:0] rem_in;
            logic [31:0] den_in;
            logic [14:0] quo_in;
            logic [46:0] cmp;
            logic        take;

            if (k == 0)
            begin : g_first
                assign rem_in = num;
                assign den_in = den;
                assign quo_in = '0;
            end
            else
            begin : g_next
                assign rem_in = rem_reg[k-1];
                assign den_in = den_reg[k-1];
                assign quo_in = quo_reg[k-1];
            end

            // Subtract the shifted divisor when it fits
            assign cmp  = {15'b0, den_in} << Bit;
            assign take = ({1'b0, rem_in} >= cmp);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= take ? 46'({1'b0, rem_in} - cmp) : rem_in;
                    den_reg[k] <= den_in;
                    quo_reg[k] <= take ? (quo_in | (15'd1 << Bit)) : quo_in;
                end
            end
        end
    endgenerate

    assign quo = quo_reg[14];

endmodule

// ===== hw/rtl/potbc_back.sv =====
`timescale 1ns / 1ps

module potbc_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  potbc_pkg::cfg_t       cfg,
    input  potbc_pkg::entry_t     head,
    input  logic                  fifo_empty,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [71:0]           out_data
);

    localparam int SQRT_LAT = 32;
    localparam int DIV_LAT  = 15;

    logic en;

    // Early stages
    logic [4:0]         v_reg;
    potbc_pkg::entry_t  e0_reg, e1_reg;
    logic [5:0]         msb_reg;
    logic [61:0]        sqx_reg, sqy_reg;
    potbc_pkg::side_t   s2_reg, s3_reg, s4_reg;
    logic [62:0]        dsum2_reg, dsum3_reg, dsum4_reg;
    logic [61:0]        sqa_reg, sqb_reg;
    logic [62:0]        lsum_reg;

    // Delay beside the square roots and dividers
    logic               vq_reg [0:SQRT_LAT-1];
    potbc_pkg::side_t   sq_reg [0:SQRT_LAT-1];
    logic               vd_reg [0:DIV_LAT-1];
    potbc_pkg::side_t   sd_reg [0:DIV_LAT-1];

    // Late stages
    logic               v5_reg, v6_reg, v7_reg, out_valid_reg;
    potbc_pkg::side_t   s5_reg, s6_reg, s7_reg;
    logic [45:0]        numx_reg, numy_reg;
    logic [31:0]        len_reg;
    logic signed [15:0] nx_reg, ny_reg;
    logic signed [31:0] pxc_reg, pys_reg, pyc_reg, pxs_reg;
    logic signed [31:0] dist_reg;
    logic signed [15:0] wx_reg, wy_reg;
    logic [3:0]         region_reg;

    logic [31:0] root_dist, root_len;
    logic [14:0] qx, qy;

    assign en        = !out_valid_reg || out_ready;
    assign pop       = en && !fifo_empty;
    assign out_valid = out_valid_reg;
    assign out_data  = {4'b0, region_reg, wy_reg, wx_reg, dist_reg};

    // Leading one of the larger offset
    logic [34:0] m_c;
    logic [5:0]  msb_c;
    always_comb
    begin
        m_c   = (e0_reg.ax > e0_reg.ay) ? e0_reg.ax : e0_reg.ay;
        msb_c = '0;
        for (int i = 0; i < 35; i++)
        begin
            if (m_c[i])
            begin
                msb_c = 6'(i);
            end
        end
    end

    // Shift both offsets so the larger leads at bit 34
    logic [5:0]  shamt_c;
    logic [34:0] tx_c, ty_c;
    always_comb
    begin
        shamt_c = 6'd34 - msb_reg;
        tx_c    = e1_reg.ax << shamt_c;
        ty_c    = e1_reg.ay << shamt_c;
    end

    potbc_sqrt u_sqrt_dist (
        .clk  (clk),
        .en   (en),
        .rad  ({1'b0, dsum4_reg}),
        .root (root_dist)
    );

    potbc_sqrt u_sqrt_len (
        .clk  (clk),
        .en   (en),
        .rad  ({1'b0, lsum_reg}),
        .root (root_len)
    );

    potbc_div u_div_x (
        .clk (clk),
        .en  (en),
        .num (numx_reg),
        .den (len_reg),
        .quo (qx)
    );

    potbc_div u_div_y (
        .clk (clk),
        .en  (en),
        .num (numy_reg),
        .den (len_reg),
        .quo (qy)
    );

    // Corner distance and local normal selection
    potbc_pkg::side_t   sq_last;
    potbc_pkg::side_t   sd_last;
    potbc_pkg::side_t   s5_c;
    logic signed [31:0] cdist_c;
    logic signed [15:0] nx_c, ny_c;
    logic signed [15:0] qx_s, qy_s;
    logic signed [32:0] wx_sum, wy_sum;

    always_comb
    begin
        sq_last = sq_reg[SQRT_LAT-1];
        sd_last = sd_reg[DIV_LAT-1];
        if (!sq_last.corner)
        begin
            cdist_c = sq_last.sdist;
        end
        else if (sq_last.sat || root_dist[31])
        begin
            cdist_c = potbc_pkg::INT32_MAX;
        end
        else
        begin
            cdist_c = $signed(root_dist);
        end
        s5_c       = sq_last;
        s5_c.sdist = cdist_c;
        qx_s = $signed({1'b0, qx});
        qy_s = $signed({1'b0, qy});
        if (sd_last.corner)
        begin
            nx_c = sd_last.ex_neg ? -qx_s : qx_s;
            ny_c = sd_last.ey_neg ? -qy_s : qy_s;
        end
        else
        begin
            nx_c = sd_last.lnx;
            ny_c = sd_last.lny;
        end
        wx_sum = $signed({pxc_reg[31], pxc_reg}) - $signed({pys_reg[31], pys_reg});
        wy_sum = $signed({pyc_reg[31], pyc_reg}) + $signed({pxs_reg[31], pxs_reg});
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            v5_reg        <= 1'b0;
            v6_reg        <= 1'b0;
            v7_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < SQRT_LAT; i++)
            begin
                vq_reg[i] <= 1'b0;
            end
            for (int i = 0; i < DIV_LAT; i++)
            begin
                vd_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            v_reg     <= {v_reg[3:0], !fifo_empty};
            vq_reg[0] <= v_reg[4];
            for (int i = 1; i < SQRT_LAT; i++)
            begin
                vq_reg[i] <= vq_reg[i-1];
            end
            v5_reg    <= vq_reg[SQRT_LAT-1];
            vd_reg[0] <= v5_reg;
            for (int i = 1; i < DIV_LAT; i++)
            begin
                vd_reg[i] <= vd_reg[i-1];
            end
            v6_reg        <= vd_reg[DIV_LAT-1];
            v7_reg        <= v6_reg;
            out_valid_reg <= v7_reg;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e0_reg  <= head;

            e1_reg  <= e0_reg;
            msb_reg <= msb_c;
            sqx_reg <= e0_reg.ax[30:0] * e0_reg.ax[30:0];
            sqy_reg <= e0_reg.ay[30:0] * e0_reg.ay[30:0];

            s2_reg.region <= e1_reg.region;
            s2_reg.corner <= e1_reg.corner;
            s2_reg.ex_neg <= e1_reg.ex_neg;
            s2_reg.ey_neg <= e1_reg.ey_neg;
            s2_reg.sat    <= (e1_reg.ax[34:31] != 4'b0) || (e1_reg.ay[34:31] != 4'b0);
            s2_reg.sdist  <= e1_reg.sdist;
            s2_reg.lnx    <= e1_reg.lnx;
            s2_reg.lny    <= e1_reg.lny;
            s2_reg.na     <= tx_c[34:4];
            s2_reg.nb     <= ty_c[34:4];
            dsum2_reg     <= {1'b0, sqx_reg} + {1'b0, sqy_reg};

            s3_reg    <= s2_reg;
            dsum3_reg <= dsum2_reg;
            sqa_reg   <= s2_reg.na * s2_reg.na;
            sqb_reg   <= s2_reg.nb * s2_reg.nb;

            s4_reg    <= s3_reg;
            dsum4_reg <= dsum3_reg;
            lsum_reg  <= {1'b0, sqa_reg} + {1'b0, sqb_reg};

            sq_reg[0] <= s4_reg;
            for (int i = 1; i < SQRT_LAT; i++)
            begin
                sq_reg[i] <= sq_reg[i-1];
            end

            s5_reg      <= s5_c;
            len_reg     <= root_len;
            numx_reg    <= {sq_last.na, 14'b0} + {15'b0, root_len[31:1]};
            numy_reg    <= {sq_last.nb, 14'b0} + {15'b0, root_len[31:1]};

            sd_reg[0] <= s5_reg;
            for (int i = 1; i < DIV_LAT; i++)
            begin
                sd_reg[i] <= sd_reg[i-1];
            end

            s6_reg <= sd_last;
            nx_reg <= nx_c;
            ny_reg <= ny_c;

            s7_reg  <= s6_reg;
            pxc_reg <= nx_reg * cfg.axis_cos;
            pys_reg <= ny_reg * cfg.axis_sin;
            pyc_reg <= ny_reg * cfg.axis_cos;
            pxs_reg <= nx_reg * cfg.axis_sin;

            dist_reg   <= s7_reg.sdist;
            region_reg <= s7_reg.region;
            wx_reg     <= potbc_pkg::clamp_axis(wx_sum[32:14]);
            wy_reg     <= potbc_pkg::clamp_axis(wy_sum[32:14]);
        end
    end

endmodule

// ===== hw/rtl/point_to_oriented_box_contact_unit.sv =====
`timescale 1ns / 1ps

// Signed distance and contact normal of a 2D point against an oriented box.
// Points stream in one per cycle and results stream out one per cycle in
// order while the output is not stalled. The front classifies the point in 6
// stages (offset, rotation products, local frame, face gaps, region, nearest
// face), a 4-entry queue follows, and the back holds two 32-stage square root
// pipes (corner distance and normal length) and two 15-stage dividers (normal
// components), which set most of the latency. Program the box through the
// write port while no point is in flight.
module point_to_oriented_box_contact_unit #(
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    // Point stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] point_x, [63:32] point_y
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // [31:0] signed_distance, [47:32] normal_x,
                                   // [63:48] normal_y, [67:64] region
);

    potbc_pkg::cfg_t   cfg_reg;
    potbc_pkg::entry_t push_data, head;
    logic              push, pop, fifo_full, fifo_empty;

    // Hold the box registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center_x    <= '0;
            cfg_reg.center_y    <= '0;
            cfg_reg.half_width  <= 31'(64'd1 << COORD_FRAC_BITS);
            cfg_reg.half_height <= 31'(64'd1 << COORD_FRAC_BITS);
            cfg_reg.axis_cos    <= potbc_pkg::AXIS_ONE;
            cfg_reg.axis_sin    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                potbc_pkg::CFG_CENTER_X:    cfg_reg.center_x    <= cfg_wdata;
                potbc_pkg::CFG_CENTER_Y:    cfg_reg.center_y    <= cfg_wdata;
                potbc_pkg::CFG_HALF_WIDTH:  cfg_reg.half_width  <= cfg_wdata[30:0];
                potbc_pkg::CFG_HALF_HEIGHT: cfg_reg.half_height <= cfg_wdata[30:0];
                potbc_pkg::CFG_AXIS_COS:    cfg_reg.axis_cos    <= cfg_wdata[15:0];
                potbc_pkg::CFG_AXIS_SIN:    cfg_reg.axis_sin    <= cfg_wdata[15:0];
                default:                    ;
            endcase
        end
    end

    potbc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .point_x   (s_tdata[31:0]),
        .point_y   (s_tdata[63:32]),
        .fifo_full (fifo_full),
        .push      (push),
        .push_data (push_data)
    );

    potbc_fifo #(
        .DEPTH (potbc_pkg::FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .full      (fifo_full),
        .empty     (fifo_empty)
    );

    potbc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head       (head),
        .fifo_empty (fifo_empty),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (m_tdata)
    );

endmodule

// ===== hw/rtl/potbc_checker.sv =====
`timescale 1ns / 1ps

module potbc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata
);

    // No result beat comes out of reset
    assert property (@(posedge clk) !rst_n |-> !m_tvalid)
        else $error("result valid during reset");

    // A stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

    // Region code and distance sign agree
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[67:64] == potbc_pkg::REGION_INSIDE)
        |-> $signed(m_tdata[31:0]) <= 0)
        else $error("inside point with positive distance");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[67:64] != potbc_pkg::REGION_INSIDE)
        |-> $signed(m_tdata[31:0]) >= 0 && m_tdata[67:64] <= potbc_pkg::REGION_RIGHT_BOTTOM)
        else $error("outside point with bad distance or region");

    // Normal components stay within unit range
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $signed(m_tdata[47:32]) <= potbc_pkg::AXIS_ONE
                  && $signed(m_tdata[47:32]) >= potbc_pkg::AXIS_NEG_ONE
                  && $signed(m_tdata[63:48]) <= potbc_pkg::AXIS_ONE
                  && $signed(m_tdata[63:48]) >= potbc_pkg::AXIS_NEG_ONE)
        else $error("normal out of range");

endmodule

bind point_to_oriented_box_contact_unit potbc_checker u_potbc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== verif/point_to_oriented_box_contact_unit_test.sv =====
`timescale 1ns / 1ps

module point_to_oriented_box_contact_unit_test;

    typedef struct {
        logic signed [31:0] sdist;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic [3:0]         region;
    } contact_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_addr = potbc_pkg::CFG_CENTER_X;
    logic [31:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;   // [31:0] point_x, [63:32] point_y
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;        // [31:0] signed_distance, [47:32] normal_x,
                                 // [63:48] normal_y, [67:64] region

    // Box as last programmed
    longint box_cx, box_cy, box_hw, box_hh, box_c, box_s;

    contact_t pending_contacts[$];
    int       mismatches = 0;
    bit       burst = 1'b0;
    int       stall_left = 0;

    point_to_oriented_box_contact_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic longint unsigned isqrt(input longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint clampl(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Distance, normal and region of one point against the current box
    function automatic contact_t predict_contact(input logic signed [31:0] px,
                                                 input logic signed [31:0] py);
        contact_t r;
        longint dx, dy, lx, ly, sdist, nx, ny, ex, ey, wx, wy;
        longint gap[4];
        longint unsigned ax, ay, m, len, lim;
        int best;
        bit corner;
        logic [3:0] region;
        dx = longint'(px) - box_cx;
        dy = longint'(py) - box_cy;
        lx = (dx * box_c + dy * box_s) >>> potbc_pkg::AXIS_FRAC;
        ly = (dy * box_c - dx * box_s) >>> potbc_pkg::AXIS_FRAC;
        sdist = 0; nx = 0; ny = 0; ex = 0; ey = 0;
        corner = 1'b0;
        if (lx < -box_hw || lx > box_hw)
        begin
            ex = (lx < -box_hw) ? lx + box_hw : lx - box_hw;
            if (ly > box_hh)
            begin
                corner = 1'b1; ey = ly - box_hh;
                region = (lx < -box_hw) ? potbc_pkg::REGION_LEFT_TOP
                                        : potbc_pkg::REGION_RIGHT_TOP;
            end
            else if (ly < -box_hh)
            begin
                corner = 1'b1; ey = ly + box_hh;
                region = (lx < -box_hw) ? potbc_pkg::REGION_LEFT_BOTTOM
                                        : potbc_pkg::REGION_RIGHT_BOTTOM;
            end
            else if (lx < -box_hw)
            begin
                region = potbc_pkg::REGION_LEFT; sdist = -box_hw - lx; nx = -16384;
            end
            else
            begin
                region = potbc_pkg::REGION_RIGHT; sdist = lx - box_hw; nx = 16384;
            end
        end
        else if (ly < -box_hh)
        begin
            region = potbc_pkg::REGION_BOTTOM; sdist = -box_hh - ly; ny = -16384;
        end
        else if (ly > box_hh)
        begin
            region = potbc_pkg::REGION_TOP; sdist = ly - box_hh; ny = 16384;
        end
        else
        begin
            // Nearest face, earlier face wins a tie
            gap[potbc_pkg::DIR_LEFT] = lx + box_hw;
            gap[potbc_pkg::DIR_RIGHT] = box_hw - lx;
            gap[potbc_pkg::DIR_BOTTOM] = ly + box_hh;
            gap[potbc_pkg::DIR_TOP] = box_hh - ly;
            best = potbc_pkg::DIR_LEFT;
            for (int k = 1; k < 4; k++)
                if (gap[k] < gap[best]) best = k;
            region = potbc_pkg::REGION_INSIDE;
            sdist = -gap[best];
            case (best)
                potbc_pkg::DIR_LEFT:   nx = -16384;
                potbc_pkg::DIR_RIGHT:  nx = 16384;
                potbc_pkg::DIR_BOTTOM: ny = -16384;
                default:               ny = 16384;
            endcase
        end
        if (corner)
        begin
            lim = 64'd1 << 31;
            ax = (ex < 0) ? longint'(-ex) : longint'(ex);
            ay = (ey < 0) ? longint'(-ey) : longint'(ey);
            if (ax >= lim || ay >= lim) sdist = 64'sd2147483647;
            else sdist = longint'(isqrt(ax * ax + ay * ay));
            m = ax > ay ? ax : ay;
            while (m >= lim)
            begin
                ax >>= 1; ay >>= 1; m >>= 1;
            end
            while (m < (lim >> 1))
            begin
                ax <<= 1; ay <<= 1; m <<= 1;
            end
            len = isqrt(ax * ax + ay * ay);
            nx = longint'((ax * 64'd16384 + len / 2) / len);
            ny = longint'((ay * 64'd16384 + len / 2) / len);
            if (ex < 0) nx = -nx;
            if (ey < 0) ny = -ny;
        end
        sdist = clampl(sdist, -64'sd2147483648, 64'sd2147483647);
        wx = clampl((nx * box_c - ny * box_s) >>> potbc_pkg::AXIS_FRAC, -16384, 16384);
        wy = clampl((ny * box_c + nx * box_s) >>> potbc_pkg::AXIS_FRAC, -16384, 16384);
        r.sdist = sdist[31:0];
        r.nx = wx[15:0];
        r.ny = wy[15:0];
        r.region = region;
        return r;
    endfunction

    // Drain: wait for every result, then for the pipe to empty
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_contacts.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            potbc_pkg::CFG_CENTER_X:    box_cx = longint'($signed(val));
            potbc_pkg::CFG_CENTER_Y:    box_cy = longint'($signed(val));
            potbc_pkg::CFG_HALF_WIDTH:  box_hw = longint'(val[30:0]);
            potbc_pkg::CFG_HALF_HEIGHT: box_hh = longint'(val[30:0]);
            potbc_pkg::CFG_AXIS_COS:    box_c = longint'($signed(val[15:0]));
            potbc_pkg::CFG_AXIS_SIN:    box_s = longint'($signed(val[15:0]));
            default: ;
        endcase
    endtask

    task automatic set_box(input logic [31:0] cx, input logic [31:0] cy,
                           input logic [31:0] hw, input logic [31:0] hh,
                           input logic [31:0] c, input logic [31:0] s);
        wait_idle();
        write_reg(potbc_pkg::CFG_CENTER_X, cx);
        write_reg(potbc_pkg::CFG_CENTER_Y, cy);
        write_reg(potbc_pkg::CFG_HALF_WIDTH, hw);
        write_reg(potbc_pkg::CFG_HALF_HEIGHT, hh);
        write_reg(potbc_pkg::CFG_AXIS_COS, c);
        write_reg(potbc_pkg::CFG_AXIS_SIN, s);
    endtask

    // Send one point beat after a random gap, record its expected contact
    task automatic send_point(input logic signed [31:0] px, input logic signed [31:0] py);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {py, px};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        pending_contacts.push_back(predict_contact(px, py));
    endtask

    // Result side: random stall after each beat
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                stall_left = burst ? 0 : $urandom_range(0, 17);
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Compare each result beat with the oldest expected contact
    always @(posedge clk)
    begin
        contact_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_contacts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat %h", m_tdata);
            end
            else
            begin
                e = pending_contacts.pop_front();
                if (m_tdata[31:0] !== e.sdist || m_tdata[47:32] !== e.nx ||
                    m_tdata[63:48] !== e.ny || m_tdata[67:64] !== e.region)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp dist %0d n (%0d,%0d) reg %0d, got %0d (%0d,%0d) %0d",
                                 e.sdist, e.nx, e.ny, e.region,
                                 $signed(m_tdata[31:0]), $signed(m_tdata[47:32]),
                                 $signed(m_tdata[63:48]), m_tdata[67:64]);
                end
            end
        end
    end

    // Every region, the face tie and the face border on the reset box
    task automatic test_regions();
        box_cx = 0; box_cy = 0; box_hw = 65536; box_hh = 65536;
        box_c = 16384; box_s = 0;
        send_point(0, 0);
        send_point(-65536, 0);
        send_point(65536, 65536);
        send_point(-200000, 1000);
        send_point(200000, -1000);
        send_point(500, -300000);
        send_point(-500, 300000);
        send_point(-100000, 90000);
        send_point(-100000, -90000);
        send_point(100000, 90000);
        send_point(100000, -90000);
        send_point(32'sh7FFF_FFFF, 32'sh8000_0000);
        send_point(32'sh8000_0000, 32'sh7FFF_FFFF);
    endtask

    // Extreme boxes: saturated corner, zero axis, widest and empty box
    task automatic test_extreme_boxes();
        set_box(32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0, 16'h4000, 16'h0);
        send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_point(32'sh8000_0000, 32'sh8000_0000);
        send_point(32'sh8000_0001, 32'sh7FFF_FFFF);
        set_box(32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hC000, 16'h4000);
        send_point(32'sh8000_0000, 32'sh8000_0000);
        send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        set_box(32'h1234_5678, 32'hFEDC_BA98, 32'h0003_0000, 32'h0001_0000, 16'h0, 16'h0);
        send_point(32'sh0, 32'sh0);
        set_box(32'h0, 32'h0, 32'h0002_0000, 32'h0001_0000, 16'h2D41, 16'hD2BF);
        send_point(32'sh0003_0000, 32'sh0003_0000);
        send_point(32'shFFFC_0000, 32'sh0001_0000);
    endtask

    function automatic logic [31:0] near_coord(input longint base, input longint span);
        longint off;
        off = longint'($urandom_range(0, 32'hFFFF_FFFF)) % (2 * span + 1) - span;
        return 32'(clampl(base + off, -64'sd2147483648, 64'sd2147483647));
    endfunction

    // Random boxes, mostly points near the box, some anywhere
    task automatic test_random_points();
        logic [31:0] cx, cy, hw, hh, c, s;
        longint span;
        for (int phase = 0; phase < 12; phase++)
        begin
            burst = (phase % 4 == 3);
            cx = (phase % 3 == 0) ? $urandom() : $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
            cy = (phase % 3 == 0) ? $urandom() : $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
            hw = (phase % 5 == 4) ? $urandom() : $urandom_range(0, 32'h0008_0000);
            hh = (phase % 5 == 4) ? $urandom() : $urandom_range(0, 32'h0008_0000);
            case (phase % 4)
                0: begin c = 16384; s = 0; end
                1: begin c = 0; s = 16'hC000; end
                2: begin c = 16'hD2BF; s = 16'h2D41; end
                default:
                begin
                    c = $urandom_range(0, 32768) - 16384;
                    s = $urandom_range(0, 32768) - 16384;
                end
            endcase
            set_box(cx, cy, hw, hh, c, s);
            span = 3 * (box_hw > box_hh ? box_hw : box_hh) + 4;
            for (int i = 0; i < 118; i++)
            begin
                if ($urandom_range(0, 9) < 2)
                    send_point($urandom(), $urandom());
                else
                    send_point(near_coord(box_cx, span), near_coord(box_cy, span));
            end
        end
        burst = 1'b0;
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_regions();
        test_extreme_boxes();
        test_random_points();
        wait_idle();
        if (mismatches == 0 && pending_contacts.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
